// ----- design/tree_barrier_node_unit_assert.svh -----
// Assertion macros used by the barrier node checker.
`ifndef TREE_BARRIER_NODE_UNIT_ASSERT_SVH
`define TREE_BARRIER_NODE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TBN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TBN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tbn_pkg.sv -----
// Types and codes of the barrier tree node.
package tbn_pkg;

  localparam int IdxW = 10;
  localparam int CntW = 11;

  // Event codes on the input stream.
  localparam logic [1:0] ACT_ENTER   = 2'd0;
  localparam logic [1:0] ACT_ARRIVE  = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  // Message kinds on the output stream.
  localparam logic [1:0] KIND_ARRIVE  = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_NODE_INDEX = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_GATHER = 3'b010,
    PH_AWAIT  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [IdxW-1:0] dest;
    logic            par;
  } msg_t;

endpackage

// ----- design/tree_barrier_node_unit.sv -----
// Barrier tree node: event decode, phase state and a three-word result buffer.
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+------------------------------------------
//  s_axis    | in  | tvalid/tready       | tuser: action, tdata: child_parity
//  m_axis    | out | tvalid/tready/tlast | tuser: kind, tdata: dest_node, sender_parity
//  cfg       | in  | cfg_we              | cfg_addr: register, cfg_data: value
//
// An event is decoded and its whole result list (up to three words) is loaded
// into the result buffer in the cycle it is accepted. The buffer sends one word
// a cycle while m_axis_tready is high, so an event's results hold the output
// until its last word leaves. The next event is taken during the cycle its
// predecessor's last word leaves. Output stalls hold the buffer and the input.
// Reset clears the phase, the child flags, the buffer count and node_index; node_count resets to 1.
module tree_barrier_node_unit #(
  parameter int MAX_NODES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] child_parity
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [9:0] dest_node, [10] sender_parity
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [10:0] cfg_data
);

  localparam int LimBits = $clog2(MAX_NODES + 1);
  localparam int CmpW    = (LimBits > 12) ? LimBits : 12;

  logic [tbn_pkg::IdxW-1:0] node_index;
  logic [tbn_pkg::CntW-1:0] node_count;
  tbn_pkg::phase_t          phase, phase_next;
  logic [1:0]               arrived, arrived_next;
  tbn_pkg::msg_t            buf_q [3];
  tbn_pkg::msg_t            buf_next [3];
  logic [1:0]               cnt, cnt_next;

  logic          in_acc, out_pop;
  logic [1:0]    action;
  logic          cpar;
  logic          hit, rel, root, has_odd, has_even, gather_done, down;
  logic [CmpW-1:0] lim, odd_w, even_w;
  tbn_pkg::phase_t ph1;
  logic [1:0]    arr1;
  tbn_pkg::msg_t e_up, e_odd, e_even, e_done;
  tbn_pkg::msg_t nw [3];
  logic [1:0]    nw_n;

  assign action  = s_axis_tuser;
  assign cpar    = s_axis_tdata[0];
  assign out_pop = m_axis_tvalid & m_axis_tready;
  assign in_acc  = s_axis_tvalid & s_axis_tready;

  // Accept out of reset when the buffer is empty or its last word leaves now.
  assign s_axis_tready = !rst && ((cnt == 2'd0) || ((cnt == 2'd1) && m_axis_tready));

  // Child existence against min(node_count, MAX_NODES).
  always_comb begin
    if (CmpW'(node_count) > CmpW'(MAX_NODES)) begin
      lim = CmpW'(MAX_NODES);
    end else begin
      lim = CmpW'(node_count);
    end
  end
  assign odd_w    = CmpW'({node_index, 1'b1});
  assign even_w   = CmpW'({node_index, 1'b0}) + CmpW'(2);
  assign has_odd  = odd_w < lim;
  assign has_even = even_w < lim;
  assign root     = (node_index == '0);

  // Candidate messages.
  always_comb begin
    e_up.kind   = tbn_pkg::KIND_ARRIVE;
    e_up.dest   = (node_index - tbn_pkg::IdxW'(1)) >> 1;
    e_up.par    = node_index[0];
    e_odd.kind  = tbn_pkg::KIND_RELEASE;
    e_odd.dest  = odd_w[tbn_pkg::IdxW-1:0];
    e_odd.par   = 1'b0;
    e_even.kind = tbn_pkg::KIND_RELEASE;
    e_even.dest = even_w[tbn_pkg::IdxW-1:0];
    e_even.par  = 1'b0;
    e_done.kind = tbn_pkg::KIND_DONE;
    e_done.dest = node_index;
    e_done.par  = 1'b0;
  end

  // Decode the event and work out the phase moves it triggers.
  always_comb begin
    hit  = 1'b0;
    rel  = 1'b0;
    ph1  = phase;
    arr1 = arrived;
    case (action)
      tbn_pkg::ACT_ENTER: begin
        if (phase == tbn_pkg::PH_IDLE) begin
          ph1 = tbn_pkg::PH_GATHER;
          hit = 1'b1;
        end
      end
      tbn_pkg::ACT_ARRIVE: begin
        arr1[cpar] = 1'b1;
        hit        = 1'b1;
      end
      tbn_pkg::ACT_RELEASE: begin
        if (phase == tbn_pkg::PH_AWAIT) begin
          rel = 1'b1;
          hit = 1'b1;
        end
      end
      default: ;
    endcase

    gather_done = hit && (ph1 == tbn_pkg::PH_GATHER) &&
                  (!has_odd || arr1[1]) && (!has_even || arr1[0]);
    down = hit && (gather_done || (ph1 == tbn_pkg::PH_AWAIT)) && (root || rel);

    phase_next   = phase;
    arrived_next = arrived;
    if (in_acc && hit) begin
      phase_next   = ph1;
      arrived_next = arr1;
      if (gather_done) begin
        arrived_next = 2'b00;
        phase_next   = tbn_pkg::PH_AWAIT;
      end
      if (down) begin
        phase_next = tbn_pkg::PH_IDLE;
      end
    end
  end

  // Build the result list: releases to existing children, then completion; or an arrival notice to the parent.
  always_comb begin
    nw[0] = e_done;
    nw[1] = e_done;
    nw[2] = e_done;
    nw_n  = 2'd0;
    if (down) begin
      case ({has_odd, has_even})
        2'b11: begin
          nw[0] = e_odd;
          nw[1] = e_even;
          nw_n  = 2'd3;
        end
        2'b10: begin
          nw[0] = e_odd;
          nw_n  = 2'd2;
        end
        2'b01: begin
          nw[0] = e_even;
          nw_n  = 2'd2;
        end
        default: nw_n = 2'd1;
      endcase
    end else if (gather_done && !root) begin
      nw[0] = e_up;
      nw_n  = 2'd1;
    end
  end

  // Shift out on pop, reload on accept.
  always_comb begin
    buf_next = buf_q;
    cnt_next = cnt;
    if (out_pop) begin
      buf_next[0] = buf_q[1];
      buf_next[1] = buf_q[2];
      cnt_next    = cnt - 2'd1;
    end
    if (in_acc) begin
      buf_next = nw;
      cnt_next = nw_n;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= tbn_pkg::PH_IDLE;
      arrived    <= 2'b00;
      cnt        <= 2'd0;
      node_index <= '0;
      node_count <= tbn_pkg::CntW'(1);
    end else begin
      phase   <= phase_next;
      arrived <= arrived_next;
      cnt     <= cnt_next;
      if (cfg_we) begin
        case (cfg_addr)
          tbn_pkg::CFG_NODE_INDEX: node_index <= cfg_data[tbn_pkg::IdxW-1:0];
          tbn_pkg::CFG_NODE_COUNT: node_count <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk) begin
    buf_q <= buf_next;
  end

  // Drive the head word.
  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tlast  = (cnt == 2'd1);
  assign m_axis_tuser  = buf_q[0].kind;
  assign m_axis_tdata  = {5'd0, buf_q[0].par, buf_q[0].dest};

endmodule

// ----- design/tbn_checker.sv -----
// Port-level checks on the barrier node and their binding.
`include "tree_barrier_node_unit_assert.svh"

module tbn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled word stays put.
  `TBN_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output word changed")

  // No new event while an output word is stalled.
  `TBN_ASSERT_NOW(a_in_blocked, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken under output stall")

  // An arrival notice is always the only word of its event.
  `TBN_ASSERT_NOW(a_arrive_last, clk, rst, m_axis_tvalid && (m_axis_tuser == tbn_pkg::KIND_ARRIVE), m_axis_tlast, "arrival notice not last")

  // A release is never the final word; completion always follows.
  `TBN_ASSERT_NOW(a_release_not_last, clk, rst, m_axis_tvalid && (m_axis_tuser == tbn_pkg::KIND_RELEASE), !m_axis_tlast, "release word marked last")

  // A release never carries sender parity.
  `TBN_ASSERT_NOW(a_release_parity, clk, rst, m_axis_tvalid && (m_axis_tuser == tbn_pkg::KIND_RELEASE), !m_axis_tdata[10], "release carries sender parity")

endmodule

bind tree_barrier_node_unit tbn_checker u_tbn_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- verif/tb_tree_barrier_node_unit.sv -----
// Self-checking bench for the barrier tree node: event words in, message words out.
module tb_tree_barrier_node_unit;

  localparam int NODE_LIMIT    = 1024;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTS    = 100;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    tbn_pkg::msg_t msg;
    logic last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [10:0] cfg_data = '0;

  // Messages still owed by the node, oldest first
  word_t pending_msgs[$];

  // Node model state and registers
  int              node_idx = 0;
  int              node_cnt = 1;
  tbn_pkg::phase_t node_phase = tbn_pkg::PH_IDLE;
  logic [1:0]      child_flags = '0;
  logic            release_flag = 1'b0;

  int err_count = 0;
  int idle_cycles = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold = 0;

  tree_barrier_node_unit #(.MAX_NODES(NODE_LIMIT)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic bit child_present(input int child);
    int lim;
    lim = (node_cnt > NODE_LIMIT) ? NODE_LIMIT : node_cnt;
    return child < lim;
  endfunction

  function automatic word_t make_msg(input logic [1:0] kind, input int dest, input logic par);
    word_t w;
    w.msg.kind = kind;
    w.msg.dest = tbn_pkg::IdxW'(dest);
    w.msg.par  = par;
    w.last     = 1'b0;
    return w;
  endfunction

  // Apply one accepted event to the node model and queue the messages it owes
  task automatic apply_event(input logic [1:0] act, input logic cpar);
    int    odd_node;
    int    even_node;
    bit    is_root;
    word_t msgs[$];
    word_t w;
    odd_node  = 2 * node_idx + 1;
    even_node = 2 * node_idx + 2;
    is_root   = (node_idx == 0);
    case (act)
      tbn_pkg::ACT_ENTER: begin
        if (node_phase != tbn_pkg::PH_IDLE) return;
        node_phase = tbn_pkg::PH_GATHER;
      end
      tbn_pkg::ACT_ARRIVE: child_flags[cpar] = 1'b1;
      tbn_pkg::ACT_RELEASE: begin
        if (node_phase != tbn_pkg::PH_AWAIT) return;
        release_flag = 1'b1;
      end
      default: return;
    endcase

    // Up phase: every present child is in, notify the parent unless this is the root
    if (node_phase == tbn_pkg::PH_GATHER && (!child_present(odd_node) || child_flags[1]) &&
        (!child_present(even_node) || child_flags[0])) begin
      if (!is_root)
        msgs.push_back(make_msg(tbn_pkg::KIND_ARRIVE, (node_idx - 1) / 2, node_idx[0]));
      child_flags = '0;
      node_phase  = tbn_pkg::PH_AWAIT;
    end

    // Down phase: release present children, then complete locally
    if (node_phase == tbn_pkg::PH_AWAIT && (is_root || release_flag)) begin
      if (child_present(odd_node))
        msgs.push_back(make_msg(tbn_pkg::KIND_RELEASE, odd_node, 1'b0));
      if (child_present(even_node))
        msgs.push_back(make_msg(tbn_pkg::KIND_RELEASE, even_node, 1'b0));
      msgs.push_back(make_msg(tbn_pkg::KIND_DONE, node_idx, 1'b0));
      release_flag = 1'b0;
      node_phase   = tbn_pkg::PH_IDLE;
    end

    foreach (msgs[i]) begin
      w = msgs[i];
      w.last = (i == msgs.size() - 1);
      pending_msgs.push_back(w);
    end
  endtask

  task automatic report_err(input string what);
    if (err_count < MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
    err_count++;
  endtask

  // Offer one event after a random gap and hold it until the node takes it
  task automatic send_event(input logic [1:0] act, input logic cpar);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {7'b0, cpar};
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    apply_event(act, cpar);
  endtask

  task automatic send_noise();
    send_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endtask

  // Stop offering, wait for every owed message, then let the node settle
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic addr, input int value);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (addr == tbn_pkg::CFG_NODE_INDEX) node_idx = value & 1023;
    else node_cnt = value & 2047;
  endtask

  task automatic set_node(input int idx, input int cnt);
    wait_drain();
    cfg_write(tbn_pkg::CFG_NODE_INDEX, idx);
    cfg_write(tbn_pkg::CFG_NODE_COUNT, cnt);
  endtask

  // Root alone, then root with both children: ignored enters, spare action,
  // early release, repeated arrivals
  task automatic test_root_cases();
    set_node(0, 1);
    send_event(tbn_pkg::ACT_ENTER, 1'b0);
    send_event(ACT_SPARE, 1'b1);
    send_event(tbn_pkg::ACT_RELEASE, 1'b1);
    send_event(tbn_pkg::ACT_ARRIVE, 1'b1);
    set_node(0, 3);
    send_event(tbn_pkg::ACT_ENTER, 1'b1);
    send_event(tbn_pkg::ACT_ENTER, 1'b0);
    send_event(tbn_pkg::ACT_ARRIVE, 1'b1);
    send_event(tbn_pkg::ACT_ARRIVE, 1'b1);
    send_event(tbn_pkg::ACT_ARRIVE, 1'b0);
  endtask

  // Inner nodes: early arrival while idle, release after notice, stray release
  task automatic test_child_nodes();
    set_node(1, 4);
    send_event(tbn_pkg::ACT_ARRIVE, 1'b1);
    send_event(tbn_pkg::ACT_ENTER, 1'b0);
    send_event(tbn_pkg::ACT_RELEASE, 1'b0);
    send_event(tbn_pkg::ACT_RELEASE, 1'b1);
    set_node(2, 1024);
    send_event(tbn_pkg::ACT_ENTER, 1'b0);
    send_event(tbn_pkg::ACT_ARRIVE, 1'b0);
    send_event(tbn_pkg::ACT_ARRIVE, 1'b1);
    send_event(tbn_pkg::ACT_RELEASE, 1'b0);
  endtask

  // Top index with an oversized count, index beyond a zero count
  task automatic test_range_limits();
    set_node(1023, 2047);
    send_event(tbn_pkg::ACT_ENTER, 1'b0);
    send_event(tbn_pkg::ACT_RELEASE, 1'b0);
    set_node(1000, 0);
    send_event(tbn_pkg::ACT_ENTER, 1'b1);
    send_event(tbn_pkg::ACT_ARRIVE, 1'b0);
    send_event(tbn_pkg::ACT_RELEASE, 1'b1);
  endtask

  // One barrier round in random order with some noise mixed in
  task automatic run_round(inout int sent);
    logic [1:0] acts[$];
    logic       pars[$];
    logic [1:0] ta;
    logic       tp;
    int         j;
    acts.push_back(tbn_pkg::ACT_ENTER);
    pars.push_back(1'($urandom_range(0, 1)));
    if (child_present(2 * node_idx + 1)) begin
      acts.push_back(tbn_pkg::ACT_ARRIVE);
      pars.push_back(1'b1);
    end
    if (child_present(2 * node_idx + 2)) begin
      acts.push_back(tbn_pkg::ACT_ARRIVE);
      pars.push_back(1'b0);
    end
    if ($urandom_range(0, 5) == 0) begin
      acts.push_back(tbn_pkg::ACT_ARRIVE);
      pars.push_back(1'($urandom_range(0, 1)));
    end
    for (int i = acts.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      ta = acts[i];
      acts[i] = acts[j];
      acts[j] = ta;
      tp = pars[i];
      pars[i] = pars[j];
      pars[j] = tp;
    end
    if (node_idx != 0 && $urandom_range(0, 7) != 0) begin
      acts.push_back(tbn_pkg::ACT_RELEASE);
      pars.push_back(1'($urandom_range(0, 1)));
    end
    foreach (acts[i]) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      send_event(acts[i], pars[i]);
      sent++;
    end
  endtask

  task automatic test_random_rounds();
    int idx;
    int cnt;
    int sent;
    for (int s = 0; s < 8; s++) begin
      if (s == 0) begin
        idx = 0;
        cnt = 2047;
      end else if (s == 1) begin
        idx = 1023;
        cnt = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            idx = $urandom_range(0, 15);
            cnt = $urandom_range(1, 40);
          end
          1: begin
            idx = $urandom_range(1, 1023);
            cnt = 2 * idx + $urandom_range(1, 3);
          end
          2: begin
            idx = $urandom_range(0, 1023);
            cnt = $urandom_range(0, 2047);
          end
          default: begin
            idx = $urandom_range(0, 511);
            cnt = 2 * idx + 3;
          end
        endcase
        if (cnt > 2047) cnt = 2047;
      end
      set_node(idx, cnt);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 14) run_round(sent);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Long receiver hold against a flooding sender, then a full pause
  task automatic test_backpressure();
    set_node(0, 3);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold = 150;
    repeat (6) begin
      send_event(tbn_pkg::ACT_ENTER, 1'b0);
      send_event(tbn_pkg::ACT_ARRIVE, 1'b1);
      send_event(tbn_pkg::ACT_ARRIVE, 1'b0);
    end
    wait_drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (4) begin
      send_event(tbn_pkg::ACT_ENTER, 1'b1);
      send_event(tbn_pkg::ACT_ARRIVE, 1'b0);
      send_event(tbn_pkg::ACT_ARRIVE, 1'b1);
    end
  endtask

  // Receiver: random or forced hold, then take one word
  initial begin : rx_side
    int gap;
    forever begin
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end else begin
        gap = rx_idle_en ? $urandom_range(0, 15) : 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk);
      while (!m_axis_tvalid) @(negedge clk);
      @(posedge clk);
    end
  end

  // Compare each word leaving the node with the oldest owed message
  always @(negedge clk) begin
    word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_msgs.size() == 0) begin
        report_err($sformatf("unexpected word kind %0d dest %0d",
                             m_axis_tuser, m_axis_tdata[9:0]));
      end else begin
        want = pending_msgs.pop_front();
        if (m_axis_tuser !== want.msg.kind)
          report_err($sformatf("kind %0d, want %0d", m_axis_tuser, want.msg.kind));
        if (m_axis_tdata[9:0] !== want.msg.dest)
          report_err($sformatf("dest_node %0d, want %0d", m_axis_tdata[9:0], want.msg.dest));
        if (m_axis_tdata[10] !== want.msg.par)
          report_err($sformatf("sender_parity %0b, want %0b", m_axis_tdata[10], want.msg.par));
        if (m_axis_tlast !== want.last)
          report_err($sformatf("last %0b, want %0b", m_axis_tlast, want.last));
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long
  always @(negedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_root_cases();
    test_child_nodes();
    test_range_limits();
    test_random_rounds();
    test_backpressure();
    wait_drain();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/tbn_pkg.sv
design/tree_barrier_node_unit.sv
design/tbn_checker.sv
verif/tb_tree_barrier_node_unit.sv
